FILE: rtl/utc_to_gps_week_seconds_unit_assert.svh
// Assertion macros for the UTC to GPS week converter.
// All checks sample on clk_i and are held off while rst_ni is low.
`ifndef UTC_TO_GPS_WEEK_SECONDS_UNIT_ASSERT_SVH
`define UTC_TO_GPS_WEEK_SECONDS_UNIT_ASSERT_SVH

// Property that must hold at every sampled edge
`define UTG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define UTG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/utg_pkg.sv
// ----------------------------------------------------------------------------
// utg_pkg
// Shared widths, calendar constants and lookup tables for the UTC to GPS
// week and seconds-of-week converter.
// ----------------------------------------------------------------------------
package utg_pkg;

  // Field widths
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DOM_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 16;
  localparam int unsigned WEEK_W  = 14;
  localparam int unsigned SOW_W   = 30;
  localparam int unsigned LEAP_W  = 8;

  // Internal widths
  localparam int unsigned DAYS_W  = 20;  // day count since epoch
  localparam int unsigned TOD_W   = 27;  // time of day plus leap offset, ms
  localparam int unsigned QUOT_W  = 18;  // days / 7

  // Calendar constants
  localparam int unsigned EPOCH_YEAR       = 1980;
  localparam int unsigned EPOCH_DAY_OFFSET = 6;
  localparam int unsigned LEAPS_BEFORE_EPOCH =
    (EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100 + (EPOCH_YEAR - 1) / 400;
  localparam logic [DAYS_W:0] DAY_BIAS =
    (DAYS_W+1)'(LEAPS_BEFORE_EPOCH + EPOCH_DAY_OFFSET);

  localparam logic [LEAP_W-1:0] LEAP_RESET = 8'd18;

  // Millisecond scale factors
  localparam logic [TOD_W-1:0] MS_PER_HOUR   = 27'd3600000;
  localparam logic [TOD_W-1:0] MS_PER_MINUTE = 27'd60000;
  localparam logic [TOD_W-1:0] MS_PER_SECOND = 27'd1000;

  // Reciprocals for constant division: floor(n*R >> S)
  localparam int unsigned DIV100_SHIFT = 19;
  localparam logic [12:0] DIV100_RECIP = 13'd5243;     // valid for n < 43690
  localparam int unsigned DIV7_SHIFT   = 23;
  localparam logic [20:0] DIV7_RECIP   = 21'd1198373;  // valid for n < 2796202

  // Days before the first of a month; month zero acts as January and
  // codes past twelve act as December.
  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    unique case (m)
      4'd0, 4'd1: d = 9'd0;
      4'd2:       d = 9'd31;
      4'd3:       d = 9'd59;
      4'd4:       d = 9'd90;
      4'd5:       d = 9'd120;
      4'd6:       d = 9'd151;
      4'd7:       d = 9'd181;
      4'd8:       d = 9'd212;
      4'd9:       d = 9'd243;
      4'd10:      d = 9'd273;
      4'd11:      d = 9'd304;
      default:    d = 9'd334;
    endcase
    return d;
  endfunction

  // Milliseconds at the start of each weekday
  function automatic logic [SOW_W-1:0] weekday_ms(input logic [2:0] r);
    logic [SOW_W-1:0] ms;
    unique case (r)
      3'd0:    ms = 30'd0;
      3'd1:    ms = 30'd86400000;
      3'd2:    ms = 30'd172800000;
      3'd3:    ms = 30'd259200000;
      3'd4:    ms = 30'd345600000;
      3'd5:    ms = 30'd432000000;
      3'd6:    ms = 30'd518400000;
      default: ms = 30'd0;
    endcase
    return ms;
  endfunction

endpackage

FILE: rtl/utg_in_if.sv
// ----------------------------------------------------------------------------
// utg_in_if
// Input channel: one UTC calendar date and time per transfer.
// ----------------------------------------------------------------------------
interface utg_in_if import utg_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DOM_W-1:0]   day_of_month;
  logic [HOUR_W-1:0]  hour;
  logic [MIN_W-1:0]   minute;
  logic [SEC_W-1:0]   second_ms;

  modport source (
    output valid, year, month, day_of_month, hour, minute, second_ms,
    input  ready
  );

  modport sink (
    input  valid, year, month, day_of_month, hour, minute, second_ms,
    output ready
  );

endinterface

FILE: rtl/utg_out_if.sv
// ----------------------------------------------------------------------------
// utg_out_if
// Output channel: GPS week number and seconds of week per transfer.
// ----------------------------------------------------------------------------
interface utg_out_if import utg_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [WEEK_W-1:0] week_number;
  logic [SOW_W-1:0]  seconds_of_week_ms;
  logic              before_epoch;

  modport source (
    output valid, week_number, seconds_of_week_ms, before_epoch,
    input  ready
  );

  modport sink (
    input  valid, week_number, seconds_of_week_ms, before_epoch,
    output ready
  );

endinterface

FILE: rtl/utc_to_gps_week_seconds_unit.sv
// Path: an input transfer is captured in stage 1, then moves through stages 2 and 3
// to out_o. Throughput: one item per cycle while out_o is ready; three register stages
// with per-stage ready, so an item enters while earlier results wait to be taken.
// Reset: all stage valids clear, leap_seconds returns to 18.
// ----------------------------------------------------------------------------
// utc_to_gps_week_seconds_unit
// Converts a UTC calendar date and time into GPS week number and seconds
// of week in milliseconds, adding a programmable leap-second offset.
// ----------------------------------------------------------------------------
module utc_to_gps_week_seconds_unit import utg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              leap_seconds_we_i,
  input  logic [LEAP_W-1:0] leap_seconds_i,
  utg_in_if.sink            in_i,
  utg_out_if.source         out_o
);

  logic [LEAP_W-1:0]  leap_q;

  // Stage 1: input register
  logic               s1_v_q;
  logic               s1_ready;
  logic [YEAR_W-1:0]  year_q;
  logic [MONTH_W-1:0] month_q;
  logic [DOM_W-1:0]   dom_q;
  logic [HOUR_W-1:0]  hour_q;
  logic [MIN_W-1:0]   minute_q;
  logic [SEC_W-1:0]   sec_q;

  // Stage 2: day count and time of day
  logic               s2_v_q;
  logic               s2_ready;
  logic [DAYS_W-1:0]  days_d, days_q;
  logic               before_d, s2_before_q;
  logic [TOD_W-1:0]   tod_d, tod_q;

  // Stage 3: result register
  logic               s3_v_q;
  logic               s3_ready;
  logic [WEEK_W-1:0]  week_d, week_q;
  logic [SOW_W-1:0]   sow_d, sow_q;
  logic               before_q;

  // Handshake chain
  assign s3_ready   = !s3_v_q || out_o.ready;
  assign s2_ready   = !s2_v_q || s3_ready;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_i.ready = s1_ready;

  // Leap second register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leap_q <= LEAP_RESET;
    end else if (leap_seconds_we_i) begin
      leap_q <= leap_seconds_i;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_ready) s1_v_q <= in_i.valid;
      if (s2_ready) s2_v_q <= s1_v_q;
      if (s3_ready) s3_v_q <= s2_v_q;
    end
  end

  // Stage 1 payload capture on input transfer
  always_ff @(posedge clk_i) begin
    if (in_i.valid && s1_ready) begin
      year_q   <= in_i.year;
      month_q  <= in_i.month;
      dom_q    <= in_i.day_of_month;
      hour_q   <= in_i.hour;
      minute_q <= in_i.minute;
      sec_q    <= in_i.second_ms;
    end
  end

  // Day count
  utg_days u_days (
    .year_i   (year_q),
    .month_i  (month_q),
    .dom_i    (dom_q),
    .days_o   (days_d),
    .before_o (before_d)
  );

  // Time of day plus leap offset, no carry into the day
  assign tod_d = TOD_W'(hour_q) * MS_PER_HOUR
               + TOD_W'(minute_q) * MS_PER_MINUTE
               + TOD_W'(sec_q)
               + TOD_W'(leap_q) * MS_PER_SECOND;

  always_ff @(posedge clk_i) begin
    if (s1_v_q && s2_ready) begin
      days_q      <= days_d;
      s2_before_q <= before_d;
      tod_q       <= tod_d;
    end
  end

  // Week split and seconds of week
  utg_sow u_sow (
    .days_i (days_q),
    .tod_i  (tod_q),
    .week_o (week_d),
    .sow_o  (sow_d)
  );

  always_ff @(posedge clk_i) begin
    if (s2_v_q && s3_ready) begin
      week_q   <= s2_before_q ? '0 : week_d;
      sow_q    <= s2_before_q ? '0 : sow_d;
      before_q <= s2_before_q;
    end
  end

  assign out_o.valid              = s3_v_q;
  assign out_o.week_number        = week_q;
  assign out_o.seconds_of_week_ms = sow_q;
  assign out_o.before_epoch       = before_q;

  // Checks
  `include "utc_to_gps_week_seconds_unit_assert.svh"

  `UTG_ASSERT(a_before_zero, !(out_o.valid && out_o.before_epoch) || ((out_o.week_number == '0) && (out_o.seconds_of_week_ms == '0)), "before_epoch result with nonzero fields")
  `UTG_ASSERT_NEXT(a_s2_hold, s2_v_q && !s3_ready, s2_v_q && $stable(days_q) && $stable(tod_q), "stage 2 lost data under stall")
  `UTG_ASSERT_NEXT(a_in_capture, in_i.valid && in_i.ready, s1_v_q, "accepted item not held in stage 1")

endmodule

FILE: rtl/utg_days.sv
// ----------------------------------------------------------------------------
// utg_days
// Closed-form Gregorian day count from the GPS epoch (1980-01-06).
// Flags dates that fall before the epoch.
// ----------------------------------------------------------------------------
module utg_days import utg_pkg::*; (
  input  logic [YEAR_W-1:0]  year_i,
  input  logic [MONTH_W-1:0] month_i,
  input  logic [DOM_W-1:0]   dom_i,
  output logic [DAYS_W-1:0]  days_o,
  output logic               before_o
);

  logic [YEAR_W-1:0]  prev_year;
  logic [YEAR_W-1:0]  year_off;
  logic [24:0]        prev_prod;
  logic [24:0]        year_prod;
  logic [5:0]         prev_q100;
  logic [5:0]         year_q100;
  logic [9:0]         prev_q4;
  logic [3:0]         prev_q400;
  logic [10:0]        leaps;
  logic [6:0]         year_r100;
  logic               is_leap;
  logic [DAYS_W:0]    year_days;
  logic [DAYS_W:0]    pos_days;

  // Leap years in 1..year-1 via reciprocal divide by 100
  assign prev_year = year_i - YEAR_W'(1);
  assign prev_prod = 25'(prev_year) * 25'(DIV100_RECIP);
  assign prev_q100 = prev_prod[DIV100_SHIFT +: 6];
  assign prev_q4   = prev_year[YEAR_W-1:2];
  assign prev_q400 = prev_q100[5:2];
  assign leaps     = 11'(prev_q4) + 11'(prev_q400) - 11'(prev_q100);

  // Leap rule for the current year
  assign year_prod = 25'(year_i) * 25'(DIV100_RECIP);
  assign year_q100 = year_prod[DIV100_SHIFT +: 6];
  assign year_r100 = 7'(year_i - 12'(year_q100 * 7'd100));
  assign is_leap   = ((year_i[1:0] == 2'b00) && (year_r100 != 7'd0)) ||
                     ((year_r100 == 7'd0) && (year_q100[1:0] == 2'b00));

  // Whole years since epoch, then month, leap day and day of month
  assign year_off  = year_i - YEAR_W'(EPOCH_YEAR);
  assign year_days = (DAYS_W+1)'(year_off) * (DAYS_W+1)'(365);
  assign pos_days  = year_days + (DAYS_W+1)'(leaps)
                   + (DAYS_W+1)'(days_before_month(month_i))
                   + (DAYS_W+1)'((month_i > MONTH_W'(2)) && is_leap)
                   + (DAYS_W+1)'(dom_i);

  assign before_o = (year_i < YEAR_W'(EPOCH_YEAR)) || (pos_days < DAY_BIAS);
  assign days_o   = DAYS_W'(pos_days - DAY_BIAS);

endmodule

FILE: rtl/utg_sow.sv
// ----------------------------------------------------------------------------
// utg_sow
// Splits the day count into weeks and weekday, and forms seconds of week
// from the weekday and the registered time of day.
// ----------------------------------------------------------------------------
module utg_sow import utg_pkg::*; (
  input  logic [DAYS_W-1:0] days_i,
  input  logic [TOD_W-1:0]  tod_i,
  output logic [WEEK_W-1:0] week_o,
  output logic [SOW_W-1:0]  sow_o
);

  logic [DAYS_W+20:0] prod;
  logic [QUOT_W-1:0]  quot;
  logic [2:0]         weekday;

  // days / 7 by reciprocal multiply; remainder from the low bits
  assign prod    = (DAYS_W+21)'(days_i) * (DAYS_W+21)'(DIV7_RECIP);
  assign quot    = prod[DIV7_SHIFT +: QUOT_W];
  assign weekday = 3'(days_i - DAYS_W'(quot * 3'd7));

  // Week number wraps at 14 bits
  assign week_o = quot[WEEK_W-1:0];
  assign sow_o  = weekday_ms(weekday) + SOW_W'(tod_i);

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTC to GPS week and seconds-of-week converter.
// A directed table of calendar corner cases runs first, then random dates
// over several leap-second settings. Both channels idle at random. Every
// result transfer is compared with its table row or a local calendar model.
// ----------------------------------------------------------------------------
module tb_top;
  import utg_pkg::*;

  localparam int unsigned LATENCY      = 3;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned PHASE_ITEMS  = 140;
  localparam int unsigned NUM_PHASES   = 6;
  localparam int unsigned NUM_DIRECTED = 23;

  // Days before the first of each month in a common year
  localparam int unsigned CUM_DAYS [12] = '{
    0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
  };

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DOM_W-1:0]   day_of_month;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second_ms;
  } utc_date_t;

  typedef struct packed {
    logic [WEEK_W-1:0] week_number;
    logic [SOW_W-1:0]  seconds_of_week_ms;
    logic              before_epoch;
  } gps_time_t;

  // typed = 1: want holds the result read straight off the calendar
  typedef struct packed {
    utc_date_t date;
    logic      typed;
    gps_time_t want;
  } date_row_t;

  logic clk_i;
  logic rst_ni;
  logic leap_we;
  logic [LEAP_W-1:0] leap_data;

  utg_in_if  in_if ();
  utg_out_if out_if ();

  utc_to_gps_week_seconds_unit i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .leap_seconds_we_i (leap_we),
    .leap_seconds_i    (leap_data),
    .in_i              (in_if),
    .out_o             (out_if)
  );

  // Directed table, leap offset at its reset value of 18 s
  date_row_t dir_rows [NUM_DIRECTED] = '{
    // GPS epoch itself
    '{'{12'd1980, 4'd1,  5'd6,  5'd0,  6'd0,  16'd0},     1'b1,
      '{14'd0, 30'd18000, 1'b0}},
    // last millisecond before the epoch
    '{'{12'd1980, 4'd1,  5'd5,  5'd23, 6'd59, 16'd59999}, 1'b1,
      '{14'd0, 30'd0, 1'b1}},
    // all fields zero
    '{'{12'd0,    4'd0,  5'd0,  5'd0,  6'd0,  16'd0},     1'b1,
      '{14'd0, 30'd0, 1'b1}},
    '{'{12'd1979, 4'd12, 5'd31, 5'd23, 6'd59, 16'd60999}, 1'b1,
      '{14'd0, 30'd0, 1'b1}},
    // first day of week one
    '{'{12'd1980, 4'd1,  5'd13, 5'd0,  6'd0,  16'd0},     1'b1,
      '{14'd1, 30'd18000, 1'b0}},
    // last millisecond of week zero
    '{'{12'd1980, 4'd1,  5'd12, 5'd23, 6'd59, 16'd59999}, 1'b1,
      '{14'd0, 30'd604817999, 1'b0}},
    // month zero acts as January
    '{'{12'd1980, 4'd0,  5'd6,  5'd0,  6'd0,  16'd0},     1'b1,
      '{14'd0, 30'd18000, 1'b0}},
    // day zero of January 1980 lies before the epoch
    '{'{12'd1980, 4'd1,  5'd0,  5'd12, 6'd0,  16'd0},     1'b1,
      '{14'd0, 30'd0, 1'b1}},
    // year below epoch with every other field at its maximum
    '{'{12'd1979, 4'd15, 5'd31, 5'd31, 6'd63, 16'd65535}, 1'b1,
      '{14'd0, 30'd0, 1'b1}},
    // day zero as last day of previous month
    '{'{12'd1980, 4'd2,  5'd0,  5'd0,  6'd0,  16'd0},     1'b0, '0},
    // time of day past range, no carry
    '{'{12'd1980, 4'd1,  5'd6,  5'd31, 6'd63, 16'd65535}, 1'b0, '0},
    // day past month end runs on
    '{'{12'd1980, 4'd2,  5'd31, 5'd0,  6'd0,  16'd0},     1'b0, '0},
    '{'{12'd1984, 4'd2,  5'd29, 5'd12, 6'd30, 16'd30500}, 1'b0, '0},
    // divisible by 400: leap year
    '{'{12'd2000, 4'd2,  5'd29, 5'd0,  6'd0,  16'd0},     1'b0, '0},
    '{'{12'd2000, 4'd3,  5'd1,  5'd0,  6'd0,  16'd0},     1'b0, '0},
    // divisible by 100 only: common year
    '{'{12'd2100, 4'd2,  5'd29, 5'd0,  6'd0,  16'd0},     1'b0, '0},
    '{'{12'd2100, 4'd3,  5'd1,  5'd0,  6'd0,  16'd0},     1'b0, '0},
    // leap second in the seconds field
    '{'{12'd2024, 4'd12, 5'd31, 5'd23, 6'd59, 16'd60999}, 1'b0, '0},
    '{'{12'd2047, 4'd6,  5'd15, 5'd10, 6'd20, 16'd30000}, 1'b0, '0},
    '{'{12'd2048, 4'd7,  5'd4,  5'd0,  6'd0,  16'd0},     1'b0, '0},
    '{'{12'd2235, 4'd12, 5'd31, 5'd23, 6'd59, 16'd60999}, 1'b0, '0},
    // month above twelve acts as December
    '{'{12'd2235, 4'd15, 5'd31, 5'd0,  6'd0,  16'd0},     1'b0, '0},
    // every field at its maximum, week number rolls over
    '{'{12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 16'd65535}, 1'b0, '0}
  };

  gps_time_t         pending_results [$];
  logic [LEAP_W-1:0] leap_model;
  int unsigned       mismatches;
  int unsigned       cycle_count;
  bit                hold_off_req;
  bit                quiet;

  // Clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Leap years in 1..n
  function automatic int unsigned leap_years_upto(input int unsigned n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  // Calendar model: GPS week and seconds of week for one UTC date
  function automatic gps_time_t gps_of_utc(input utc_date_t d,
                                           input logic [LEAP_W-1:0] leap);
    gps_time_t       res;
    int unsigned     yr;
    int unsigned     mon;
    int              days;
    longint unsigned sow;
    res = '0;
    yr  = 32'(d.year);
    if (yr < EPOCH_YEAR) begin
      res.before_epoch = 1'b1;
      return res;
    end
    if (d.month == 4'd0) mon = 1;
    else if (d.month > 4'd12) mon = 12;
    else mon = 32'(d.month);
    days = int'(365 * (yr - EPOCH_YEAR) + leap_years_upto(yr - 1)
                - leap_years_upto(EPOCH_YEAR - 1) + CUM_DAYS[mon - 1]);
    if (mon > 2 && (((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0)) days += 1;
    days += int'(d.day_of_month) - 6;
    if (days < 0) begin
      res.before_epoch = 1'b1;
      return res;
    end
    sow = 64'(days % 7) * 64'd86400000 + 64'(d.hour) * 64'd3600000
        + 64'(d.minute) * 64'd60000 + 64'(d.second_ms) + 64'(leap) * 64'd1000;
    res.week_number        = WEEK_W'(days / 7);
    res.seconds_of_week_ms = SOW_W'(sow);
    return res;
  endfunction

  // Mostly well-formed dates, some near the epoch, some raw noise
  function automatic utc_date_t random_date();
    utc_date_t   d;
    int unsigned pick;
    int unsigned mlen;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      d.year         = YEAR_W'($urandom_range(0, 4095));
      d.month        = MONTH_W'($urandom_range(0, 15));
      d.day_of_month = DOM_W'($urandom_range(0, 31));
      d.hour         = HOUR_W'($urandom_range(0, 31));
      d.minute       = MIN_W'($urandom_range(0, 63));
      d.second_ms    = SEC_W'($urandom_range(0, 65535));
    end else begin
      if (pick < 3) begin
        d.year         = YEAR_W'($urandom_range(1979, 1980));
        d.month        = MONTH_W'($urandom_range(0, 2));
        d.day_of_month = DOM_W'($urandom_range(0, 12));
      end else begin
        d.year  = YEAR_W'($urandom_range(1980, 2235));
        d.month = MONTH_W'($urandom_range(1, 12));
        if (d.month == 4'd2) mlen = 28;
        else if (d.month == 4'd4 || d.month == 4'd6 || d.month == 4'd9 ||
                 d.month == 4'd11) mlen = 30;
        else mlen = 31;
        d.day_of_month = DOM_W'($urandom_range(1, mlen));
      end
      d.hour   = HOUR_W'($urandom_range(0, 23));
      d.minute = MIN_W'($urandom_range(0, 59));
      // occasional leap second
      if ($urandom_range(0, 15) == 0) d.second_ms = SEC_W'($urandom_range(60000, 60999));
      else d.second_ms = SEC_W'($urandom_range(0, 59999));
    end
    return d;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Offer one date and hold it until the transfer; then queue its result
  task automatic send_date(input utc_date_t d, input logic typed, input gps_time_t want);
    in_if.valid        <= 1'b1;
    in_if.year         <= d.year;
    in_if.month        <= d.month;
    in_if.day_of_month <= d.day_of_month;
    in_if.hour         <= d.hour;
    in_if.minute       <= d.minute;
    in_if.second_ms    <= d.second_ms;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    pending_results.push_back(typed ? want : gps_of_utc(d, leap_model));
  endtask

  // Random sender idle burst
  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every queued result has come out
  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_leap_seconds(input logic [LEAP_W-1:0] value);
    leap_we   <= 1'b1;
    leap_data <= value;
    @(posedge clk_i);
    leap_model = value;
    leap_we   <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    logic [LEAP_W-1:0] leap_val;
    rst_ni             = 1'b0;
    leap_we            = 1'b0;
    leap_data          = '0;
    in_if.valid        = 1'b0;
    in_if.year         = '0;
    in_if.month        = '0;
    in_if.day_of_month = '0;
    in_if.hour         = '0;
    in_if.minute       = '0;
    in_if.second_ms    = '0;
    leap_model         = LEAP_RESET;
    mismatches         = 0;
    hold_off_req       = 1'b0;
    quiet              = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      sender_gap();
      send_date(dir_rows[i].date, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      wait_results_drained();
      if (ph == 0) leap_val = '0;
      else if (ph == 1) leap_val = '1;
      else if (ph == NUM_PHASES - 1) leap_val = LEAP_RESET;
      else leap_val = LEAP_W'($urandom_range(0, 255));
      write_leap_seconds(leap_val);
      // long receiver stall fills the pipeline
      if (ph == 1) hold_off_req = 1'b1;
      // last phase runs with no idling
      if (ph == NUM_PHASES - 1) quiet = 1'b1;
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == PHASE_ITEMS / 2) wait_results_drained();
        sender_gap();
        send_date(random_date(), 1'b0, '0);
      end
    end

    wait_results_drained();
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // Receiver ready: random stall bursts, one long hold on request
  initial begin
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Result checker: each transfer against the oldest queued result
  always @(posedge clk_i) begin : check_result
    gps_time_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with no date pending");
      end else begin
        want = pending_results.pop_front();
        if (out_if.week_number !== want.week_number)
          report_mismatch($sformatf("week_number %0d, want %0d",
                                    out_if.week_number, want.week_number));
        if (out_if.seconds_of_week_ms !== want.seconds_of_week_ms)
          report_mismatch($sformatf("seconds_of_week_ms %0d, want %0d",
                                    out_if.seconds_of_week_ms, want.seconds_of_week_ms));
        if (out_if.before_epoch !== want.before_epoch)
          report_mismatch($sformatf("before_epoch %0b, want %0b",
                                    out_if.before_epoch, want.before_epoch));
      end
    end
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

FILE: utc_to_gps_week_seconds_unit.f
+incdir+rtl
rtl/utg_pkg.sv
rtl/utg_in_if.sv
rtl/utg_out_if.sv
rtl/utg_days.sv
rtl/utg_sow.sv
rtl/utc_to_gps_week_seconds_unit.sv
sim/tb_top.sv
